// File: rtl/rgb_median_filter_3x3_unit_macros.svh
// assertion macros for the rgb median filter unit
// used by the top level only, needs clk and rst_n in scope
`ifndef RGB_MEDIAN_FILTER_3X3_UNIT_MACROS_SVH
`define RGB_MEDIAN_FILTER_3X3_UNIT_MACROS_SVH

// implication checked at every clock edge outside reset
`define RMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked at the next clock edge
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant checked at every clock edge outside reset
`define RMF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// File: rtl/rmf_pkg.sv
// shared types, constants and compare functions for the rgb median filter
// no dependencies
package rmf_pkg;

    localparam int MaxWidth  = 2048;
    localparam int AddrW     = $clog2(MaxWidth);
    localparam int DimW      = 12;
    localparam int RowW      = 13;

    localparam logic [DimW-1:0] WidthRst  = 12'd640;
    localparam logic [DimW-1:0] HeightRst = 12'd480;
    localparam logic [DimW-1:0] DimMin    = 12'd3;
    localparam logic [DimW-1:0] WidthMax  = 12'd2048;

    localparam logic CmdPixel = 1'b0;
    localparam logic CmdFlush = 1'b1;

    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] md;
        logic [7:0] hi;
    } ch3_t;

    typedef struct packed {
        ch3_t r;
        ch3_t g;
        ch3_t b;
    } srt_t;

    typedef struct packed {
        logic interior;
        logic row_end;
        logic frame_end;
    } flags_t;

    function automatic logic [7:0] min2(logic [7:0] a, logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(logic [7:0] a, logic [7:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [7:0] med3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic ch3_t sort3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        ch3_t s;
        s.lo = min2(min2(a, b), c);
        s.md = med3(a, b, c);
        s.hi = max2(max2(a, b), c);
        return s;
    endfunction

endpackage

// File: rtl/rmf_line_store.sv
// one line store: 24-bit pixels, one write and one registered read per cycle
// depends on rmf_pkg
module rmf_line_store
    import rmf_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  pix_t             wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output pix_t             rdata
);

    pix_t mem [MaxWidth];
    pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rmf_cell.sv
// window cell: holds one column of three pixels, passes it on, sorts it per channel
// depends on rmf_pkg
module rmf_cell
    import rmf_pkg::*;
(
    input  logic clk,
    input  logic load,
    input  col_t din,
    output col_t dout,
    output srt_t srt
);

    col_t col_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg <= din;
        end
    end

    assign dout  = col_reg;
    assign srt.r = sort3(col_reg.top.r, col_reg.mid.r, col_reg.bot.r);
    assign srt.g = sort3(col_reg.top.g, col_reg.mid.g, col_reg.bot.g);
    assign srt.b = sort3(col_reg.top.b, col_reg.mid.b, col_reg.bot.b);

endmodule

// File: rtl/rmf_median.sv
// median combine over three sorted columns plus output register
// depends on rmf_pkg
module rmf_median
    import rmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       win_valid,
    output logic       win_ready,
    input  srt_t       c0,
    input  srt_t       c1,
    input  srt_t       c2,
    input  pix_t       center,
    input  flags_t     flags,
    output logic       res_valid,
    input  logic       res_ready,
    output pix_t       res_pix,
    output logic       res_row_end,
    output logic       res_frame_end
);

    logic   s3_vld_reg;
    srt_t   s3_tri_reg;
    pix_t   s3_ctr_reg;
    flags_t s3_flg_reg;
    logic   o_vld_reg;
    pix_t   o_pix_reg;
    logic   o_re_reg;
    logic   o_fe_reg;
    logic   mv3;
    logic   mv4;
    srt_t   tri_next;
    pix_t   med_next;

    assign mv4       = !o_vld_reg || res_ready;
    assign mv3       = !s3_vld_reg || mv4;
    assign win_ready = mv3;

    // max of lows, median of mids, min of highs
    assign tri_next.r.lo = max2(max2(c0.r.lo, c1.r.lo), c2.r.lo);
    assign tri_next.r.md = med3(c0.r.md, c1.r.md, c2.r.md);
    assign tri_next.r.hi = min2(min2(c0.r.hi, c1.r.hi), c2.r.hi);
    assign tri_next.g.lo = max2(max2(c0.g.lo, c1.g.lo), c2.g.lo);
    assign tri_next.g.md = med3(c0.g.md, c1.g.md, c2.g.md);
    assign tri_next.g.hi = min2(min2(c0.g.hi, c1.g.hi), c2.g.hi);
    assign tri_next.b.lo = max2(max2(c0.b.lo, c1.b.lo), c2.b.lo);
    assign tri_next.b.md = med3(c0.b.md, c1.b.md, c2.b.md);
    assign tri_next.b.hi = min2(min2(c0.b.hi, c1.b.hi), c2.b.hi);

    assign med_next.r = med3(s3_tri_reg.r.lo, s3_tri_reg.r.md, s3_tri_reg.r.hi);
    assign med_next.g = med3(s3_tri_reg.g.lo, s3_tri_reg.g.md, s3_tri_reg.g.hi);
    assign med_next.b = med3(s3_tri_reg.b.lo, s3_tri_reg.b.md, s3_tri_reg.b.hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (mv3)
            begin
                s3_vld_reg <= win_valid;
            end
            if (mv4)
            begin
                o_vld_reg <= s3_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv3 && win_valid)
        begin
            s3_tri_reg <= tri_next;
            s3_ctr_reg <= center;
            s3_flg_reg <= flags;
        end
        if (mv4 && s3_vld_reg)
        begin
            o_pix_reg <= s3_flg_reg.interior ? med_next : s3_ctr_reg;
            o_re_reg  <= s3_flg_reg.row_end;
            o_fe_reg  <= s3_flg_reg.frame_end;
        end
    end

    assign res_valid     = o_vld_reg;
    assign res_pix       = o_pix_reg;
    assign res_row_end   = o_re_reg;
    assign res_frame_end = o_fe_reg;

endmodule

// File: rtl/rgb_median_filter_3x3_unit.sv
// top level of the streaming 3x3 rgb median filter
// depends on rmf_pkg, rmf_line_store, rmf_cell, rmf_median and the macros header
//
// channel   direction  handshake              payload
// pixel     in         pix_valid/pix_ready    cmd, red, green, blue
// result    out        res_valid/res_ready    out_red, out_green, out_blue, row_end, frame_end
// config    in         psel/penable/pready    paddr, pwdata, prdata
//
// one transaction per cycle while the result side does not stall; a result passes four
// registers after its triggering pixel (line store read, window cell, combine, output register)
// reset is asynchronous; line stores are not cleared and need no clearing pass
// a stall on the result side backs up stage by stage, bubbles are squeezed out
`include "rgb_median_filter_3x3_unit_macros.svh"

module rgb_median_filter_3x3_unit
    import rmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  logic        cmd,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        row_end,
    output logic        frame_end
);

    logic [DimW-1:0]  width_reg;
    logic [DimW-1:0]  height_reg;
    logic [AddrW-1:0] col_reg;
    logic [RowW-1:0]  row_reg;

    logic             s1_vld_reg;
    pix_t             s1_pix_reg;
    logic [AddrW-1:0] s1_col_reg;
    logic             s1_emit_reg;
    flags_t           s1_flg_reg;
    logic             s2_vld_reg;
    flags_t           s2_flg_reg;

    logic             cfg_wr;
    logic [DimW-1:0]  cfg_val;
    logic             acc;
    logic             draining;
    logic             take;
    pix_t             pix_in;
    logic             emit;
    logic [DimW-1:0]  wm1;
    logic [RowW-1:0]  hm1;
    logic [DimW-1:0]  ocol;
    logic [RowW-1:0]  orow;
    flags_t           flg;
    logic             col_last;
    logic             mv1;
    logic             mv2;
    logic             s1_mv;
    logic             med_ready;
    pix_t             mem_a_q;
    pix_t             mem_b_q;
    col_t             cin;
    col_t             c0_out;
    col_t             c1_out;
    col_t             c2_out;
    srt_t             c0_srt;
    srt_t             c1_srt;
    srt_t             c2_srt;
    pix_t             res_pix;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_val = (pwdata[DimW-1:0] < DimMin) ? DimMin : pwdata[DimW-1:0];
    assign prdata  = (paddr[2] == RegHeight) ? {20'b0, height_reg} : {20'b0, width_reg};

    // position bookkeeping at acceptance
    assign acc      = pix_valid && pix_ready;
    assign draining = row_reg >= {1'b0, height_reg};
    assign take     = acc && !(cmd == CmdFlush && !draining);
    assign pix_in   = draining ? '0 : pix_t'{r: red, g: green, b: blue};
    assign emit     = (row_reg >= RowW'(2)) || (row_reg == RowW'(1) && col_reg != '0);
    assign wm1      = width_reg - DimW'(1);
    assign hm1      = {1'b0, height_reg} - RowW'(1);
    assign ocol     = (col_reg == '0) ? wm1 : ({1'b0, col_reg} - DimW'(1));
    assign orow     = (col_reg == '0) ? (row_reg - RowW'(2)) : (row_reg - RowW'(1));
    assign col_last = ({1'b0, col_reg} == wm1);

    assign flg.interior  = (ocol != '0) && (ocol < wm1) && (orow != '0) && (orow < hm1);
    assign flg.row_end   = (ocol == wm1);
    assign flg.frame_end = (ocol == wm1) && (orow == hm1);

    // stall chain
    assign mv2       = !s2_vld_reg || med_ready;
    assign mv1       = !s1_vld_reg || mv2;
    assign s1_mv     = s1_vld_reg && mv2;
    assign pix_ready = mv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WidthRst;
            height_reg <= HeightRst;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                RegWidth:
                begin
                    width_reg <= (cfg_val > WidthMax) ? WidthMax : cfg_val;
                end
                RegHeight:
                begin
                    height_reg <= cfg_val;
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            if (emit && flg.frame_end)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_reg + RowW'(1);
            end
            else
            begin
                col_reg <= col_reg + AddrW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (mv1)
            begin
                s1_vld_reg <= take;
            end
            if (mv2)
            begin
                s2_vld_reg <= s1_vld_reg && s1_emit_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv1 && take)
        begin
            s1_pix_reg  <= pix_in;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= emit;
            s1_flg_reg  <= flg;
        end
        if (s1_mv)
        begin
            s2_flg_reg <= s1_flg_reg;
        end
    end

    rmf_line_store u_store_a (
        .clk   (clk),
        .we    (s1_mv),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (take),
        .raddr (col_reg),
        .rdata (mem_a_q)
    );

    rmf_line_store u_store_b (
        .clk   (clk),
        .we    (s1_mv),
        .waddr (s1_col_reg),
        .wdata (mem_a_q),
        .re    (take),
        .raddr (col_reg),
        .rdata (mem_b_q)
    );

    // window: newest column enters cell 2 and moves toward cell 0
    assign cin = col_t'{top: mem_b_q, mid: mem_a_q, bot: s1_pix_reg};

    rmf_cell u_cell2 (
        .clk  (clk),
        .load (s1_mv),
        .din  (cin),
        .dout (c2_out),
        .srt  (c2_srt)
    );

    rmf_cell u_cell1 (
        .clk  (clk),
        .load (s1_mv),
        .din  (c2_out),
        .dout (c1_out),
        .srt  (c1_srt)
    );

    rmf_cell u_cell0 (
        .clk  (clk),
        .load (s1_mv),
        .din  (c1_out),
        .dout (c0_out),
        .srt  (c0_srt)
    );

    rmf_median u_median (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_valid     (s2_vld_reg),
        .win_ready     (med_ready),
        .c0            (c0_srt),
        .c1            (c1_srt),
        .c2            (c2_srt),
        .center        (c1_out.mid),
        .flags         (s2_flg_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_pix       (res_pix),
        .res_row_end   (row_end),
        .res_frame_end (frame_end)
    );

    assign out_red   = res_pix.r;
    assign out_green = res_pix.g;
    assign out_blue  = res_pix.b;

    // first column of a new frame may meet the last write of the previous frame
    `RMF_ASSERT_ALWAYS(a_col_in_range, {1'b0, col_reg} < width_reg, "column past row width")
    `RMF_ASSERT_IMP(a_no_rw_clash, s1_mv && take && (row_reg != '0), s1_col_reg != col_reg, "line store clash")
    `RMF_ASSERT_IMP(a_frame_end_row_end, res_valid && frame_end, row_end, "frame end off row end")
    `RMF_ASSERT_NEXT(a_cell_follows_s1, s2_vld_reg && !mv2, $stable(c1_out.bot), "window moved on stall")

endmodule
